### rtl/mam_pkg.sv
package mam_pkg;

    localparam int W     = 64;              // datapath width, R = 2^W
    localparam int HW    = 32;              // multiplier slice width
    localparam int NDIV  = 2 * W;           // restoring division steps, one per stage
    localparam int NRED  = 8;               // REDC pipeline depth
    localparam int NDLY  = NDIV - NRED;     // alignment delay after REDC
    localparam int NEWTON = 6;              // Newton steps for the inverse

    typedef enum logic [2:0] {
        ACT_MUL  = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_TOM  = 3'd3,
        ACT_FROM = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        INV_IDLE,
        INV_P1,
        INV_S1,
        INV_P2,
        INV_S2
    } t_inv_state;

endpackage

### rtl/mam_inv_seq.sv
module mam_inv_seq
    import mam_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [W-1:0] i_cfg_wdata,
    output logic [W-1:0] o_mod,
    output logic [W-1:0] o_neg_inv,
    output logic         o_busy
);

    t_inv_state r_state, n_state;
    logic [2:0]      r_cnt;
    logic [W-1:0]    r_mod, r_ninv, r_inv, r_e;
    logic [2*HW-1:0] r_pa, r_pb, r_pc;
    logic [W-1:0]    w_x, w_y, w_lo;
    logic [HW-1:0]   w_mid;

    // operand select for the shared low-half multiplier
    always_comb begin
        if (r_state == INV_P2) begin
            w_x = r_inv;
            w_y = r_e;
        end else begin
            w_x = r_mod;
            w_y = r_inv;
        end
    end

    // low 64 bits of the product from the registered slices
    assign w_mid = r_pb[HW-1:0] + r_pc[HW-1:0];
    assign w_lo  = r_pa + {w_mid, {HW{1'b0}}};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            INV_IDLE: n_state = INV_IDLE;
            INV_P1:   n_state = INV_S1;
            INV_S1:   n_state = INV_P2;
            INV_P2:   n_state = INV_S2;
            INV_S2:   n_state = (r_cnt == 3'(NEWTON - 1)) ? INV_IDLE : INV_P1;
            default:  n_state = INV_IDLE;
        endcase
        if (i_cfg_we) n_state = INV_P1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= INV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= W'(1);
            r_ninv <= '1;
            r_inv  <= W'(1);
            r_cnt  <= '0;
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_wdata;
            r_inv <= W'(1);
            r_cnt <= '0;
        end else if (r_state == INV_S2) begin
            r_inv <= w_lo;
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'(NEWTON - 1)) r_ninv <= W'(0) - w_lo;
        end
    end

    // slice products and the correction term
    always_ff @(posedge i_clk) begin
        r_pa <= w_x[HW-1:0]  * w_y[HW-1:0];
        r_pb <= w_x[HW-1:0]  * w_y[W-1:HW];
        r_pc <= w_x[W-1:HW]  * w_y[HW-1:0];
        if (r_state == INV_S1) r_e <= W'(2) - w_lo;
    end

    assign o_mod     = r_mod;
    assign o_neg_inv = r_ninv;
    assign o_busy    = (r_state != INV_IDLE);

endmodule

### rtl/mam_redc_pipe.sv
module mam_redc_pipe
    import mam_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_adv,
    input  logic [2:0]   i_act,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_mod,
    input  logic [W-1:0] i_neg_inv,
    output logic [W-1:0] o_res
);

    logic [2:0]      r_act [NRED-1];
    logic [W-1:0]    r_aux [1:NRED-2];
    logic [2*W-1:0]  r_t   [2:NRED-2];
    logic [2*HW-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [W:0]      r_sum, r_diff;
    logic [2*HW-1:0] r_qa, r_qb, r_qc;
    logic [W-1:0]    r_q;
    logic [2*HW-1:0] r_m00, r_m01, r_m10, r_m11;
    logic [2*W-1:0]  r_qm;
    logic [W:0]      r_u;
    logic [W-1:0]    r_res;

    logic [W-1:0]    w_b;
    logic [2*W-1:0]  w_t, w_qm;
    logic [W-1:0]    w_aux, w_q, w_red;
    logic [HW-1:0]   w_qmid;
    logic [2*W:0]    w_s;

    // from-Montgomery form multiplies by one
    assign w_b = (t_action'(i_act) == ACT_FROM) ? W'(1) : i_b;

    // stage 1: slice products, add and subtract raw terms
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_act[0] <= i_act;
            r_p00 <= i_a[HW-1:0] * w_b[HW-1:0];
            r_p01 <= i_a[HW-1:0] * w_b[W-1:HW];
            r_p10 <= i_a[W-1:HW] * w_b[HW-1:0];
            r_p11 <= i_a[W-1:HW] * w_b[W-1:HW];
            r_sum  <= {1'b0, i_a} + {1'b0, w_b};
            r_diff <= {1'b0, i_a} - {1'b0, w_b};
        end
    end

    // stage 2: full product, modular add or subtract correction
    assign w_t = {{W{1'b0}}, r_p00} + {{HW{1'b0}}, r_p01, {HW{1'b0}}}
               + {{HW{1'b0}}, r_p10, {HW{1'b0}}} + {r_p11, {W{1'b0}}};

    always_comb begin
        case (t_action'(r_act[0]))
            ACT_ADD: w_aux = (r_sum[W] || (r_sum[W-1:0] >= i_mod))
                             ? (r_sum[W-1:0] - i_mod) : r_sum[W-1:0];
            ACT_SUB: w_aux = r_diff[W] ? (i_mod + r_diff[W-1:0]) : r_diff[W-1:0];
            default: w_aux = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_act[1] <= r_act[0];
            r_aux[1] <= w_aux;
            r_t[2]   <= w_t;
        end
    end

    // stage 3: slices of q = t_low * neg_inv
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_qa <= r_t[2][HW-1:0]  * i_neg_inv[HW-1:0];
            r_qb <= r_t[2][HW-1:0]  * i_neg_inv[W-1:HW];
            r_qc <= r_t[2][W-1:HW]  * i_neg_inv[HW-1:0];
        end
    end

    // stage 4: q modulo 2^64
    assign w_qmid = r_qb[HW-1:0] + r_qc[HW-1:0];
    assign w_q    = r_qa + {w_qmid, {HW{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_adv) r_q <= w_q;
    end

    // stage 5: slices of q * modulus
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m00 <= r_q[HW-1:0] * i_mod[HW-1:0];
            r_m01 <= r_q[HW-1:0] * i_mod[W-1:HW];
            r_m10 <= r_q[W-1:HW] * i_mod[HW-1:0];
            r_m11 <= r_q[W-1:HW] * i_mod[W-1:HW];
        end
    end

    // stage 6: q * modulus
    assign w_qm = {{W{1'b0}}, r_m00} + {{HW{1'b0}}, r_m01, {HW{1'b0}}}
                + {{HW{1'b0}}, r_m10, {HW{1'b0}}} + {r_m11, {W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_adv) r_qm <= w_qm;
    end

    // stage 7: (t + q*m) >> 64 kept with its carry
    assign w_s = {1'b0, r_t[NRED-2]} + {1'b0, r_qm};

    always_ff @(posedge i_clk) begin
        if (i_adv) r_u <= w_s[2*W:W];
    end

    // stage 8: conditional subtract and result select
    assign w_red = (r_u >= {1'b0, i_mod}) ? W'(r_u - {1'b0, i_mod}) : r_u[W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            case (t_action'(r_act[NRED-2]))
                ACT_MUL, ACT_FROM: r_res <= w_red;
                ACT_ADD, ACT_SUB:  r_res <= r_aux[NRED-2];
                default:           r_res <= '0;
            endcase
        end
    end

    // side lines for action, add/sub result and t
    generate
        for (genvar k = 2; k < NRED - 1; k++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_act[k] <= r_act[k-1];
                    r_aux[k] <= r_aux[k-1];
                end
            end
        end
        for (genvar k = 3; k < NRED - 1; k++) begin : g_tline
            always_ff @(posedge i_clk) begin
                if (i_adv) r_t[k] <= r_t[k-1];
            end
        end
    endgenerate

    assign o_res = r_res;

endmodule

### rtl/mam_div_row.sv
module mam_div_row
    import mam_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_adv,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_mod,
    output logic [W-1:0] o_rem
);

    // one restoring step per stage over the dividend a * 2^64
    logic [W-1:0] r_rem  [NDIV];
    logic [W-1:0] r_bits [NDIV];

    generate
        for (genvar k = 0; k < NDIV; k++) begin : g_step
            logic [W-1:0] w_prem, w_pbits;
            logic [W:0]   w_t;
            if (k == 0) begin : g_first
                assign w_prem  = '0;
                assign w_pbits = i_a;
            end else begin : g_next
                assign w_prem  = r_rem[k-1];
                assign w_pbits = r_bits[k-1];
            end
            assign w_t = {w_prem, w_pbits[W-1]};
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k]  <= (w_t >= {1'b0, i_mod}) ? W'(w_t - {1'b0, i_mod})
                                                        : w_t[W-1:0];
                    r_bits[k] <= {w_pbits[W-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_rem = r_rem[NDIV-1];

endmodule

### rtl/montgomery_modular_alu_top.sv
// 64-bit Montgomery modular ALU (R = 2^64). Fully pipelined: one operation
// per cycle, with the pipeline depth set by
// the 128-stage restoring division that forms (a * 2^64) mod m for the
// to-Montgomery operation; the other operations run through an 8-stage REDC
// pipeline and are delayed to match. Writing the modulus starts a
// Newton sequence for -m^-1 mod 2^64, during which no input is taken. The
// whole pipeline stalls while a result waits at the output.
module montgomery_modular_alu_top
    import mam_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [W-1:0]   i_cfg_wdata,      // modulus
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [2*W-1:0] i_s_axis_tdata,   // [63:0] operand_a, [127:64] operand_b
    input  logic [7:0]     i_s_axis_tuser,   // [2:0] action, rest zero
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [W-1:0]   o_m_axis_tdata    // [63:0] result
);

    logic           w_adv, w_busy, w_in_ok;
    logic [W-1:0]   w_mod, w_ninv, w_red, w_rem;
    logic [NDIV:0]  r_vld;
    logic [2:0]     r_act [NDIV];
    logic [W-1:0]   r_dly [NDLY];
    logic [W-1:0]   r_out;
    logic [2:0]     r_out_act;

    // global advance: the pipeline moves unless the output is held
    assign w_adv           = !r_vld[NDIV] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv && !w_busy;
    assign w_in_ok         = i_s_axis_tvalid && o_s_axis_tready;

    mam_inv_seq u_inv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_mod       (w_mod),
        .o_neg_inv   (w_ninv),
        .o_busy      (w_busy)
    );

    mam_redc_pipe u_redc (
        .i_clk     (i_clk),
        .i_adv     (w_adv),
        .i_act     (i_s_axis_tuser[2:0]),
        .i_a       (i_s_axis_tdata[W-1:0]),
        .i_b       (i_s_axis_tdata[2*W-1:W]),
        .i_mod     (w_mod),
        .i_neg_inv (w_ninv),
        .o_res     (w_red)
    );

    mam_div_row u_div (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_a   (i_s_axis_tdata[W-1:0]),
        .i_mod (w_mod),
        .o_rem (w_rem)
    );

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NDIV-1:0], w_in_ok};
        end
    end

    // action line and REDC alignment delay
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_act[0] <= i_s_axis_tuser[2:0];
            r_dly[0] <= w_red;
            for (int k = 1; k < NDIV; k++) r_act[k] <= r_act[k-1];
            for (int k = 1; k < NDLY; k++) r_dly[k] <= r_dly[k-1];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_act <= r_act[NDIV-1];
            if (t_action'(r_act[NDIV-1]) == ACT_TOM) begin
                r_out <= (w_mod == '0) ? '0 : w_rem;
            end else begin
                r_out <= r_dly[NDLY-1];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NDIV];
    assign o_m_axis_tdata  = r_out;

    // no transfer in while the inverse is being derived
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> !w_busy)
        else $error("input transfer during inverse derivation");

    // a modulus write always starts the derivation
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> w_busy)
        else $error("modulus write did not start inverse derivation");

    // unused action codes give zero
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_out_act > 3'(ACT_FROM))) |-> (o_m_axis_tdata == '0))
        else $error("unused action gave non-zero result");

    // input is held back only by the sequencer or a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_s_axis_tready && !w_busy) |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without cause");

endmodule

### verif/testbench.sv
module testbench;
    import mam_pkg::*;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } t_alu_op;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [63:0]    i_cfg_wdata = '0;
    logic           i_s_axis_tvalid = 1'b0;
    logic           o_s_axis_tready;
    logic [127:0]   i_s_axis_tdata = '0;  // [63:0] operand_a, [127:64] operand_b
    logic [7:0]     i_s_axis_tuser = '0;  // [2:0] action, rest zero
    logic           o_m_axis_tvalid;
    logic           i_m_axis_tready = 1'b0;
    logic [63:0]    o_m_axis_tdata;       // [63:0] result

    montgomery_modular_alu_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the ring and its inverse
    logic [63:0] ring_mod = 64'd1;
    logic [63:0] ring_ninv = '1;
    t_alu_op     op_backlog[$];
    logic [63:0] result_fifo[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    int          drv_gap = 0;
    int          mon_gap = 0;

    function automatic logic [63:0] neg_inverse_of(logic [63:0] m);
        logic [63:0] inv;
        inv = 64'd1;
        for (int i = 0; i < 6; i++) inv = inv * (64'd2 - m * inv);
        return -inv;
    endfunction

    function automatic logic [63:0] redc_product(logic [63:0] a, logic [63:0] b);
        logic [127:0] t;
        logic [63:0]  q;
        logic [128:0] s;
        logic [64:0]  u;
        t = a * b;
        q = t[63:0] * ring_ninv;
        s = {1'b0, t} + ({65'd0, q} * {65'd0, ring_mod});
        u = s[128:64];
        if (u >= {1'b0, ring_mod}) u = u - {1'b0, ring_mod};
        return u[63:0];
    endfunction

    function automatic logic [63:0] alu_result(t_alu_op op);
        logic [64:0]  s;
        logic [127:0] w;
        case (op.action)
            ACT_MUL:  return redc_product(op.op_a, op.op_b);
            ACT_ADD: begin
                s = {1'b0, op.op_a} + {1'b0, op.op_b};
                if (s[64] || s[63:0] >= ring_mod) return s[63:0] - ring_mod;
                return s[63:0];
            end
            ACT_SUB:  return (op.op_a >= op.op_b) ? op.op_a - op.op_b
                                                  : ring_mod - (op.op_b - op.op_a);
            ACT_TOM: begin
                if (ring_mod == 64'd0) return 64'd0;
                w = {op.op_a, 64'd0} % {64'd0, ring_mod};
                return w[63:0];
            end
            ACT_FROM: return redc_product(op.op_a, 64'd1);
            default:  return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // operand mostly a residue, sometimes an edge or anything at all
    function automatic logic [63:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80 && ring_mod > 64'd1) return rand64() % ring_mod;
        if (r < 85) return ring_mod - 64'd1;
        if (r < 88) return 64'd0;
        if (r < 91) return '1;
        return rand64();
    endfunction

    // driver: one transfer per handshake, random gap bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                result_fifo.push_back(alu_result({i_s_axis_tuser[2:0],
                                                  i_s_axis_tdata[63:0],
                                                  i_s_axis_tdata[127:64]}));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (op_backlog.size() > 0) begin
                    t_alu_op op;
                    op = op_backlog.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser  <= {5'd0, op.action};
                    i_s_axis_tdata  <= {op.op_b, op.op_a};
                    if (!quiet && $urandom_range(0, 9) == 0)
                        drv_gap <= $urandom_range(1, 6);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (result_fifo.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %h", o_m_axis_tdata);
                end else begin
                    logic [63:0] want;
                    want = result_fifo.pop_front();
                    if (want !== o_m_axis_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %h got %h",
                                     want, o_m_axis_tdata);
                    end
                end
            end
            if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                i_m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                mon_gap <= $urandom_range(0, 5);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (op_backlog.size() > 0 || i_s_axis_tvalid || result_fifo.size() > 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic load_modulus(logic [63:0] m);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ring_mod  = m;
        ring_ninv = neg_inverse_of(m);
    endtask

    task automatic queue_op(logic [2:0] act, logic [63:0] a, logic [63:0] b);
        op_backlog.push_back('{act, a, b});
    endtask

    task automatic queue_random(int n);
        logic [2:0] act;
        for (int i = 0; i < n; i++) begin
            act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            queue_op(act, pick_operand(), pick_operand());
        end
    endtask

    // stimulus
    initial begin
        logic [63:0] moduli[8];
        moduli = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5, 64'd3,
                   64'h8000_0000_0000_0001, 64'd0, 64'h0000_0000_0001_0000,
                   64'd1, 64'hFFFF_FFFF_FFFF_FFFF};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset modulus of one
        queue_op(ACT_MUL, 64'd5, 64'd7);
        queue_op(ACT_TOM, '1, 64'd0);

        // directed: largest odd modulus, every action code, field extremes
        load_modulus('1);
        for (int k = 0; k < 8; k++) queue_op(3'(k), '1 - 64'd1, '1 - 64'd1);
        for (int k = 0; k < 5; k++) queue_op(3'(k), 64'd0, 64'd0);
        queue_op(ACT_ADD, '1, '1);
        queue_op(ACT_SUB, 64'd0, '1);
        queue_op(ACT_MUL, '1, '1);
        queue_op(ACT_FROM, 64'd1, '1);
        queue_op(ACT_TOM, '1, 64'd0);

        // random phases across moduli; last one with no idling
        for (int p = 0; p < 8; p++) begin
            if (p == 3) load_modulus(rand64() | 64'd1);
            load_modulus(moduli[p]);
            if (p == 7) begin
                wait_drained();
                quiet = 1'b1;
            end
            queue_random(p == 6 ? 120 : 130);
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && result_fifo.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
